// ===== design/hcbp_pkg.sv =====
// Shared constants and codes for the Huffman code bit packer.
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int FUNC_W       = 2;
  localparam int SYMBOL_W     = 8;
  localparam int CODE_VALUE_W = 32;
  localparam int CODE_LEN_W   = 6;
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = 7;
  localparam int PEND_CNT_W   = 3;

  localparam int IN_TDATA_W   = ((SYMBOL_W + CODE_VALUE_W + CODE_LEN_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

endpackage

// ===== design/hcbp_table.sv =====
// Code table memory: one write port, one registered read port.
module hcbp_table #(
  parameter int DEPTH  = hcbp_pkg::SYMBOL_COUNT,
  parameter int DATA_W = hcbp_pkg::CODE_VALUE_W + 6
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o
);
  import hcbp_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/hcbp_packer.sv =====
// Packing stage: merges a looked-up code with the pending bits into output bytes.
module hcbp_packer #(
  parameter int MAXL = hcbp_pkg::MAX_CODE_LEN,
  parameter int NB   = (MAXL + 7) / 8,
  parameter int LW   = $clog2(MAXL + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hcbp_pkg::func_e               in_func_i,
  input  logic                          in_ok_i,
  input  logic [hcbp_pkg::CODE_VALUE_W-1:0] entry_value_i,
  input  logic [LW-1:0]                 entry_len_i,
  output logic                          grp_valid_o,
  input  logic                          grp_ready_i,
  output logic [NB*8-1:0]               grp_bytes_o,
  output logic [$clog2(NB+1)-1:0]       grp_count_o
);
  import hcbp_pkg::*;

  localparam int CW  = (NB + 1) * 8;
  localparam int TW  = $clog2(MAXL + 8);
  localparam int NBW = $clog2(NB + 1);
  localparam int EW  = MAXL + CODE_VALUE_W;

  logic                  s1_valid_q;
  func_e                 s1_func_q;
  logic                  s1_ok_q;
  logic [PEND_W-1:0]     pend_q, pend_d;
  logic [PEND_CNT_W-1:0] pcnt_q, pcnt_d;

  logic [LW-1:0]   clen;
  logic [EW-1:0]   code_ext;
  logic [MAXL-1:0] code_la;
  logic [CW-1:0]   comb;
  logic [TW-1:0]   total;
  logic [NBW-1:0]  nb;
  logic [PEND_W-1:0] enc_pend;
  logic            s1_fire;

  always_comb begin
    clen     = (32'(entry_len_i) > MAXL) ? LW'(MAXL) : entry_len_i;
    code_ext = EW'(entry_value_i) << (LW'(MAXL) - clen);
    code_la  = code_ext[MAXL-1:0];
    comb     = {pend_q, {(CW-PEND_W){1'b0}}} | ({code_la, {(CW-MAXL){1'b0}}} >> pcnt_q);
    total    = TW'(pcnt_q) + TW'(clen);
    nb       = NBW'(total >> 3);
    enc_pend = '0;
    for (int k = 0; k <= NB; k++) begin
      if (nb == NBW'(k)) begin
        enc_pend = comb[CW-1-8*k -: PEND_W];
      end
    end
  end

  always_comb begin
    grp_bytes_o = '0;
    grp_count_o = '0;
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    case (s1_func_q)
      FUNC_ENCODE: begin
        if (s1_ok_q) begin
          for (int k = 0; k < NB; k++) begin
            grp_bytes_o[8*k +: 8] = comb[CW-1-8*k -: 8];
          end
          grp_count_o = nb;
          pend_d      = enc_pend;
          pcnt_d      = total[PEND_CNT_W-1:0];
        end
      end
      FUNC_FLUSH: begin
        grp_bytes_o[BYTE_W-1:0] = {pend_q, 1'b0};
        grp_count_o = (pcnt_q != '0) ? NBW'(1) : '0;
        pend_d      = '0;
        pcnt_d      = '0;
      end
      default: begin
      end
    endcase
  end

  assign grp_valid_o = s1_valid_q && (grp_count_o != '0);
  assign s1_fire     = s1_valid_q && ((grp_count_o == '0) || grp_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= '0;
      pcnt_q     <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_func_q <= in_func_i;
      s1_ok_q   <= in_ok_i;
    end
  end

  a_pend_low_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PEND_W'(pend_q << pcnt_q) == '0)
    else $error("pending bits below the count are not clear");

  a_grp_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_o |-> (32'(grp_count_o) <= NB))
    else $error("byte group larger than the emitter holds");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(pend_q) && $stable(pcnt_q)))
    else $error("stalled packing stage lost its transaction or state");

endmodule

// ===== design/hcbp_emitter.sv =====
// Output buffer: holds one group of packed bytes and sends them one per transaction.
module hcbp_emitter #(
  parameter int NB = (hcbp_pkg::MAX_CODE_LEN + 7) / 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       grp_valid_i,
  output logic                       grp_ready_o,
  input  logic [NB*8-1:0]            grp_bytes_i,
  input  logic [$clog2(NB+1)-1:0]    grp_count_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [hcbp_pkg::BYTE_W-1:0] m_axis_tdata_o,  // out_byte[7:0]
  output logic                       m_axis_tlast_o    // last_of_run
);
  import hcbp_pkg::*;

  localparam int NBW = $clog2(NB + 1);

  logic [NB*8-1:0] bytes_q;
  logic [NBW-1:0]  rem_q;
  logic            m_fire;
  logic            load;

  assign m_axis_tvalid_o = (rem_q != '0);
  assign m_axis_tdata_o  = bytes_q[BYTE_W-1:0];
  assign m_axis_tlast_o  = (rem_q == NBW'(1));
  assign m_fire          = m_axis_tvalid_o && m_axis_tready_i;
  assign grp_ready_o     = (rem_q == '0) || (m_axis_tlast_o && m_axis_tready_i);
  assign load            = grp_valid_i && grp_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load) begin
      rem_q <= grp_count_i;
    end else if (m_fire) begin
      rem_q <= rem_q - NBW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= grp_bytes_i;
    end else if (m_fire) begin
      bytes_q <= bytes_q >> BYTE_W;
    end
  end

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast_o && !load) |=> !m_axis_tvalid_o)
    else $error("output still valid after the final byte of a group");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (rem_q == $past(grp_count_i)))
    else $error("byte count not taken from the loaded group");

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// Top level of the table-driven Huffman code bit packer.
// Each input transaction is a load (write one code table entry), an encode (append the
// code of a byte to the pending bits) or a flush (send the zero-padded partial byte and
// clear the pending bits). An input transaction can be taken every cycle unless the
// packing stage is stalled by the output buffer: it is registered together with its table
// read, packed in the following cycle and handed to an output buffer that sends one byte per
// cycle while tready is high, earliest bit in bit 7, with tlast on the final byte of each
// input transaction. An encode produces up to (MAX_CODE_LEN + 7) / 8 bytes, four by default;
// loads, encodes that complete no byte and empty flushes send nothing. Lengths are clamped
// to 1..MAX_CODE_LEN on load, and symbols at or above SYMBOL_COUNT are dropped. Encoding a
// never-loaded entry is undefined.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // symbol[7:0], code_value[39:8], code_length[45:40], zero[47:46]
  input  logic [hcbp_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // func[1:0]
  input  logic [hcbp_pkg::FUNC_W-1:0]     s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_byte[7:0]
  output logic [hcbp_pkg::BYTE_W-1:0]     m_axis_tdata_o,
  // last_of_run
  output logic                            m_axis_tlast_o
);
  import hcbp_pkg::*;

  localparam int NB  = (MAX_CODE_LEN + 7) / 8;
  localparam int LW  = $clog2(MAX_CODE_LEN + 1);
  localparam int AW  = $clog2(SYMBOL_COUNT);
  localparam int EW  = CODE_VALUE_W + LW;
  localparam int NBW = $clog2(NB + 1);

  logic [SYMBOL_W-1:0]     sym;
  logic [CODE_VALUE_W-1:0] val;
  logic [CODE_LEN_W-1:0]   len;
  func_e                   func;
  logic                    sym_ok;
  logic                    accept;
  logic [LW-1:0]           len_c;
  logic [CODE_VALUE_W-1:0] val_mask;
  logic [EW-1:0]           rd_entry;

  logic                    grp_valid;
  logic                    grp_ready;
  logic [NB*8-1:0]         grp_bytes;
  logic [NBW-1:0]          grp_count;

  assign sym    = s_axis_tdata_i[SYMBOL_W-1:0];
  assign val    = s_axis_tdata_i[SYMBOL_W +: CODE_VALUE_W];
  assign len    = s_axis_tdata_i[SYMBOL_W+CODE_VALUE_W +: CODE_LEN_W];
  assign func   = func_e'(s_axis_tuser_i);
  assign sym_ok = (32'(sym) < SYMBOL_COUNT);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (len == '0) begin
      len_c = LW'(1);
    end else if (32'(len) > MAX_CODE_LEN) begin
      len_c = LW'(MAX_CODE_LEN);
    end else begin
      len_c = LW'(len);
    end
    if (32'(len_c) >= CODE_VALUE_W) begin
      val_mask = '1;
    end else begin
      val_mask = CODE_VALUE_W'(((CODE_VALUE_W+1)'(1) << len_c) - (CODE_VALUE_W+1)'(1));
    end
  end

  hcbp_table #(
    .DEPTH  (SYMBOL_COUNT),
    .DATA_W (EW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (accept && (func == FUNC_LOAD) && sym_ok),
    .wr_addr_i (sym[AW-1:0]),
    .wr_data_i ({len_c, val & val_mask}),
    .rd_en_i   (accept),
    .rd_addr_i (sym[AW-1:0]),
    .rd_data_o (rd_entry)
  );

  hcbp_packer #(
    .MAXL (MAX_CODE_LEN),
    .NB   (NB),
    .LW   (LW)
  ) u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_func_i     (func),
    .in_ok_i       (sym_ok),
    .entry_value_i (rd_entry[CODE_VALUE_W-1:0]),
    .entry_len_i   (rd_entry[EW-1:CODE_VALUE_W]),
    .grp_valid_o   (grp_valid),
    .grp_ready_i   (grp_ready),
    .grp_bytes_o   (grp_bytes),
    .grp_count_o   (grp_count)
  );

  hcbp_emitter #(
    .NB (NB)
  ) u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .grp_valid_i     (grp_valid),
    .grp_ready_o     (grp_ready),
    .grp_bytes_i     (grp_bytes),
    .grp_count_i     (grp_count),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== tb/huffman_code_bit_packer_test.sv =====
// Self-checking testbench for the Huffman code bit packer: directed and random transactions.
module huffman_code_bit_packer_test;
  import hcbp_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEM_COUNT    = 470;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 50;
  localparam int DRAIN_AT      = 200;
  localparam int PAD_W         = IN_TDATA_W - SYMBOL_W - CODE_VALUE_W - CODE_LEN_W;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } coded_byte_t;

  class packer_scoreboard;
    logic [CODE_VALUE_W-1:0] code_bits [SYMBOL_COUNT];
    int unsigned             code_len  [SYMBOL_COUNT];
    logic [PEND_W-1:0]       held_bits;
    int unsigned             held_count;
    coded_byte_t             bytes_due [$];
    int                      errors;

    function new();
      held_bits  = '0;
      held_count = 0;
      errors     = 0;
      foreach (code_len[i]) begin
        code_bits[i] = '0;
        code_len[i]  = 0;
      end
    endfunction

    function logic [63:0] low_ones(int unsigned n);
      return (64'd1 << n) - 64'd1;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task note_input(logic [FUNC_W-1:0] fn, logic [SYMBOL_W-1:0] sym,
                    logic [CODE_VALUE_W-1:0] val, logic [CODE_LEN_W-1:0] len);
      logic [63:0] acc;
      int unsigned total;
      int unsigned clen;
      coded_byte_t cb;
      case (fn)
        FUNC_LOAD: begin
          if (len == 0) clen = 1;
          else if (len > MAX_CODE_LEN) clen = MAX_CODE_LEN;
          else clen = 32'(len);
          code_len[sym]  = clen;
          code_bits[sym] = val & CODE_VALUE_W'(low_ones(clen));
        end
        FUNC_ENCODE: begin
          clen  = code_len[sym];
          acc   = ({57'd0, held_bits} << clen) | {32'd0, code_bits[sym]};
          total = held_count + clen;
          while (total >= 8) begin
            cb.value = BYTE_W'(acc >> (total - 8));
            cb.last  = (total < 16);
            bytes_due.push_back(cb);
            total -= 8;
          end
          held_bits  = acc[PEND_W-1:0] & PEND_W'(low_ones(total));
          held_count = total;
        end
        FUNC_FLUSH: begin
          if (held_count != 0) begin
            cb.value = {1'b0, held_bits} << (8 - held_count);
            cb.last  = 1'b1;
            bytes_due.push_back(cb);
          end
          held_bits  = '0;
          held_count = 0;
        end
        default: ;
      endcase
    endtask

    task check_result(logic [BYTE_W-1:0] value, logic last);
      coded_byte_t want;
      if (bytes_due.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", value, last));
        return;
      end
      want = bytes_due.pop_front();
      if (value !== want.value)
        report($sformatf("byte %02h, expected %02h", value, want.value));
      if (last !== want.last)
        report($sformatf("tlast %0b, expected %0b", last, want.last));
    endtask

    task check_drained();
      if (bytes_due.size() != 0)
        report($sformatf("%0d bytes never sent", bytes_due.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n   = 1'b0;
  logic                  s_valid = 1'b0;
  logic [IN_TDATA_W-1:0] s_data  = '0;
  logic [FUNC_W-1:0]     s_user  = '0;
  logic                  m_ready = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [BYTE_W-1:0]     m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  packer_scoreboard sb = new();
  bit               sym_loaded [SYMBOL_COUNT];
  int unsigned      loaded_syms [$];
  bit               tx_burst = 1'b0;
  bit               rx_burst = 1'b0;

  huffman_code_bit_packer DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
      if (s_valid && s_axis_tready_o)
        sb.note_input(s_user, s_data[SYMBOL_W-1:0],
                      s_data[SYMBOL_W +: CODE_VALUE_W],
                      s_data[SYMBOL_W+CODE_VALUE_W +: CODE_LEN_W]);
    end
  end

  task automatic send_item(logic [FUNC_W-1:0] fn, logic [SYMBOL_W-1:0] sym,
                           logic [CODE_VALUE_W-1:0] val, logic [CODE_LEN_W-1:0] len);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {{PAD_W{1'b0}}, len, val, sym};
    s_user  <= fn;
    if (fn == FUNC_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    do @(posedge clk); while (!s_axis_tready_o);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (sb.bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int                      pick;
    logic [SYMBOL_W-1:0]     sym;
    logic [CODE_VALUE_W-1:0] val;
    logic [CODE_LEN_W-1:0]   len;
    pick = $urandom_range(0, 99);
    sym  = SYMBOL_W'($urandom_range(0, SYMBOL_COUNT - 1));
    val  = $urandom();
    len  = CODE_LEN_W'($urandom_range(0, 63));
    if (loaded_syms.size() == 0 || pick < 15) begin
      if ($urandom_range(0, 7) != 0) len = CODE_LEN_W'($urandom_range(1, MAX_CODE_LEN));
      send_item(FUNC_LOAD, sym, val, len);
    end else if (pick < 82) begin
      sym = SYMBOL_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
      send_item(FUNC_ENCODE, sym, val, len);
    end else if (pick < 94) begin
      send_item(FUNC_FLUSH, sym, val, len);
    end else begin
      send_item(FUNC_UNUSED, sym, val, len);
    end
  endtask

  // Receiver: random stalls, one long hold-off to back up the input side.
  initial begin
    int stall;
    int seen;
    bit held;
    seen = 0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 5);
      if (seen == HOLD_AFTER && !held) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid_o);
      seen++;
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(FUNC_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32);
    send_item(FUNC_LOAD,   8'd255, 32'h0000_0000, 6'd1);
    send_item(FUNC_LOAD,   8'd1,   32'hFFFF_FFFF, 6'd0);
    send_item(FUNC_LOAD,   8'd2,   32'hA5A5_A5A5, 6'd33);
    send_item(FUNC_LOAD,   8'd3,   32'hDEAD_BEEF, 6'd63);
    send_item(FUNC_LOAD,   8'd4,   32'h1234_5675, 6'd3);
    send_item(FUNC_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
    send_item(FUNC_UNUSED, 8'hC3,  32'h5A5A_F00F, 6'h2A);
    send_item(FUNC_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd4,   32'h0000_0000, 6'd0);
    send_item(FUNC_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd2,   32'hFFFF_FFFF, 6'h3F);
    send_item(FUNC_ENCODE, 8'd3,   32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd4,   32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd4,   32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd1,   32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd4,   32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd4,   32'h0000_0000, 6'd0);
    send_item(FUNC_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
    send_item(FUNC_FLUSH,  8'hFF,  32'hFFFF_FFFF, 6'h3F);
    send_item(FUNC_LOAD,   8'd0,   32'hFFFF_FF5A, 6'd8);
    send_item(FUNC_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
    send_item(FUNC_FLUSH,  8'd0,   32'h0000_0000, 6'd0);

    for (int i = 0; i < ITEM_COUNT - 25; i++) begin
      if (i == DRAIN_AT) wait_drained();
      send_random_item();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
